[rtl/b64d_pkg.sv]
// Shared types, codes and constants for the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int ACC_W      = 12;
    localparam int PEND_W     = 3;
    localparam int SYM_W      = 6;
    localparam int LIMIT_W    = 17;

    // Hard cap on decoded bytes per string, combined with the limit register.
    localparam logic [LIMIT_W-1:0] MaxLength = LIMIT_W'(256);

    localparam logic [COUNT_W-1:0] MAX_OUT_RESET = COUNT_W'(256);

    localparam int TOKEN_FIFO_DEPTH = 4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    localparam logic [1:0] TOK_SYM     = 2'd0;
    localparam logic [1:0] TOK_END     = 2'd1;
    localparam logic [1:0] TOK_PAD     = 2'd2;
    localparam logic [1:0] TOK_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SYM_W-1:0] value;
    } b64d_token_t;

endpackage

[rtl/base64_stream_decoder.sv]
// Top level of the base64 stream decoder: classifier, token queue, decode engine.
// Path: a pushed character is written into the token queue, then decoded into the
// result register, from which its word can be popped.
// Throughput: one character per cycle while the result register is empty or being popped.
// Reset: queues empty, decode state cleared, byte limit register set to 256.
`timescale 1ns / 1ps

module base64_stream_decoder #(
    parameter int FIFO_DEPTH = b64d_pkg::TOKEN_FIFO_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [b64d_pkg::CHAR_W-1:0]   char_code,
    input  logic                          cfg_wr_en,
    input  logic [b64d_pkg::COUNT_W-1:0]  cfg_wr_data,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    data_byte,
    output logic                          byte_valid,
    output logic                          finished,
    output logic [b64d_pkg::STATUS_W-1:0] status,
    output logic [b64d_pkg::COUNT_W-1:0]  decoded_length
);
    import b64d_pkg::*;

    b64d_token_t in_token;
    b64d_token_t q_token;
    logic        q_empty;
    logic        q_take;

    b64d_front u_front (
        .char_code (char_code),
        .token     (in_token)
    );

    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_token),
        .full    (full),
        .rd_en   (q_take),
        .rd_data (q_token),
        .empty   (q_empty)
    );

    b64d_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .token          (q_token),
        .token_avail    (!q_empty),
        .token_take     (q_take),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .finished       (finished),
        .status         (status),
        .decoded_length (decoded_length),
        .empty          (empty),
        .pop            (pop)
    );

endmodule

[rtl/b64d_front.sv]
// Front end: classifies each input character into a decoder token.
`timescale 1ns / 1ps

module b64d_front (
    input  logic [b64d_pkg::CHAR_W-1:0] char_code,
    output b64d_pkg::b64d_token_t       token
);
    import b64d_pkg::*;

    logic [CHAR_W-1:0] sym;

    always_comb
    begin
        token.kind = TOK_INVALID;
        sym        = '0;
        if (char_code == 8'h00)
        begin
            token.kind = TOK_END;
        end
        else if (char_code inside {[8'h41:8'h5A]})
        begin
            token.kind = TOK_SYM;
            sym        = char_code - 8'h41;
        end
        else if (char_code inside {[8'h61:8'h7A]})
        begin
            token.kind = TOK_SYM;
            sym        = char_code - 8'h61 + 8'd26;
        end
        else if (char_code inside {[8'h30:8'h39]})
        begin
            token.kind = TOK_SYM;
            sym        = char_code - 8'h30 + 8'd52;
        end
        else if (char_code == 8'h2B)
        begin
            token.kind = TOK_SYM;
            sym        = 8'd62;
        end
        else if (char_code == 8'h2F)
        begin
            token.kind = TOK_SYM;
            sym        = 8'd63;
        end
        else if (char_code == 8'h3D)
        begin
            token.kind = TOK_PAD;
        end
        token.value = sym[SYM_W-1:0];
    end

endmodule

[rtl/b64d_fifo.sv]
// Short token queue between the classifier and the decode engine.
`timescale 1ns / 1ps

module b64d_fifo #(
    parameter int DEPTH = b64d_pkg::TOKEN_FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  b64d_pkg::b64d_token_t wr_data,
    output logic                  full,
    input  logic                  rd_en,
    output b64d_pkg::b64d_token_t rd_data,
    output logic                  empty
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    b64d_token_t    mem [DEPTH];
    logic [AW-1:0]  wptr_reg, wptr_next;
    logic [AW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr, do_rd;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == LAST) ? '0 : wptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == LAST) ? '0 : rptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/b64d_back.sv]
// Decode engine: bit accumulator, byte count, skip state and result register.
`timescale 1ns / 1ps

module b64d_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [b64d_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  b64d_pkg::b64d_token_t         token,
    input  logic                          token_avail,
    output logic                          token_take,
    output logic [7:0]                    data_byte,
    output logic                          byte_valid,
    output logic                          finished,
    output logic [b64d_pkg::STATUS_W-1:0] status,
    output logic [b64d_pkg::COUNT_W-1:0]  decoded_length,
    output logic                          empty,
    input  logic                          pop
);
    import b64d_pkg::*;

    logic [COUNT_W-1:0]  max_out_reg;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                skip_reg, skip_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_data_reg, out_data_next;
    logic                out_bv_reg, out_bv_next;
    logic                out_fin_reg, out_fin_next;
    logic [STATUS_W-1:0] out_st_reg, out_st_next;
    logic [COUNT_W-1:0]  out_len_reg, out_len_next;

    logic                slot_free;
    logic                emit;
    logic [ACC_W-1:0]    acc_shifted;
    logic [PEND_W-1:0]   shift;
    logic [LIMIT_W-1:0]  limit;
    logic [ACC_W-1:0]    byte_word;

    assign slot_free  = !out_valid_reg || pop;
    assign token_take = token_avail && slot_free;

    assign acc_shifted = {acc_reg[ACC_W-SYM_W-1:0], token.value};
    assign shift       = pend_reg - PEND_W'(2);
    assign byte_word   = acc_shifted >> shift;
    assign limit       = (MaxLength < LIMIT_W'(max_out_reg)) ? MaxLength
                                                              : LIMIT_W'(max_out_reg);

    always_comb
    begin
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        count_next    = count_reg;
        skip_next     = skip_reg;
        emit          = 1'b0;
        out_data_next = 8'h00;
        out_bv_next   = 1'b0;
        out_fin_next  = 1'b0;
        out_st_next   = STATUS_OK;
        out_len_next  = count_reg;
        if (token_take)
        begin
            if (skip_reg)
            begin
                // drop everything up to the terminating zero
                if (token.kind == TOK_END)
                begin
                    acc_next   = '0;
                    pend_next  = '0;
                    count_next = '0;
                    skip_next  = 1'b0;
                end
            end
            else
            begin
                case (token.kind)
                    TOK_END:
                    begin
                        emit         = 1'b1;
                        out_fin_next = 1'b1;
                        acc_next     = '0;
                        pend_next    = '0;
                        count_next   = '0;
                    end
                    TOK_PAD:
                    begin
                        emit         = 1'b1;
                        out_fin_next = 1'b1;
                        skip_next    = 1'b1;
                    end
                    TOK_INVALID:
                    begin
                        emit         = 1'b1;
                        out_fin_next = 1'b1;
                        out_st_next  = STATUS_INVALID;
                        skip_next    = 1'b1;
                    end
                    TOK_SYM:
                    begin
                        acc_next = acc_shifted;
                        if (pend_reg < PEND_W'(2))
                        begin
                            pend_next = pend_reg + PEND_W'(6);
                        end
                        else if (LIMIT_W'(count_reg) >= limit)
                        begin
                            emit         = 1'b1;
                            out_fin_next = 1'b1;
                            out_st_next  = STATUS_FULL;
                            skip_next    = 1'b1;
                        end
                        else
                        begin
                            emit          = 1'b1;
                            pend_next     = shift;
                            count_next    = count_reg + COUNT_W'(1);
                            out_data_next = byte_word[7:0];
                            out_bv_next   = 1'b1;
                            out_len_next  = count_reg + COUNT_W'(1);
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_out_reg   <= MAX_OUT_RESET;
            acc_reg       <= '0;
            pend_reg      <= '0;
            count_reg     <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_out_reg <= cfg_wr_data;
            end
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= out_data_next;
            out_bv_reg   <= out_bv_next;
            out_fin_reg  <= out_fin_next;
            out_st_reg   <= out_st_next;
            out_len_reg  <= out_len_next;
        end
    end

    assign empty          = !out_valid_reg;
    assign data_byte      = out_data_reg;
    assign byte_valid     = out_bv_reg;
    assign finished       = out_fin_reg;
    assign status         = out_st_reg;
    assign decoded_length = out_len_reg;

endmodule

[verif/tb.sv]
// Self-checking testbench for the base64 stream decoder: directed table, then random strings.
`timescale 1ns / 1ps

module tb;
    import b64d_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 3000;
    localparam int GROUP_ITEMS  = 66;
    localparam int LONG_CHARS   = 345;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0]          data;
        logic                valid;
        logic                fin;
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  len;
    } dec_word_t;

    typedef enum logic {ROW_CHAR, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [8:0]         val;
        logic               lit_on;
        logic               lit_has;
        dec_word_t          lit;
    } row_t;

    localparam dec_word_t NO_WORD = '0;

    // Rows with lit_on set carry their expected word; the rest go to the predictor.
    localparam row_t DIR_ROWS [0:27] = '{
        '{ROW_CHAR,  "A",    1'b1, 1'b0, NO_WORD},
        '{ROW_CHAR,  "Z",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "a",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "z",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "0",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "9",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "+",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "/",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "=",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "Q",    1'b1, 1'b0, NO_WORD},
        '{ROW_CHAR,  9'h000, 1'b1, 1'b0, NO_WORD},
        '{ROW_CHAR,  9'h000, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_OK, 9'd0}},
        '{ROW_CHAR,  9'h0FF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_INVALID, 9'd0}},
        '{ROW_CHAR,  9'h080, 1'b1, 1'b0, NO_WORD},
        '{ROW_CHAR,  9'h000, 1'b1, 1'b0, NO_WORD},
        '{ROW_CHAR,  "/",    1'b1, 1'b0, NO_WORD},
        '{ROW_CHAR,  "/",    1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, STATUS_OK, 9'd1}},
        '{ROW_CHAR,  9'h000, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_OK, 9'd1}},
        '{ROW_LIMIT, 9'd0,   1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "A",    1'b1, 1'b0, NO_WORD},
        '{ROW_CHAR,  "A",    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_FULL, 9'd0}},
        '{ROW_CHAR,  9'h000, 1'b1, 1'b0, NO_WORD},
        '{ROW_LIMIT, 9'd1,   1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "/",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "/",    1'b0, 1'b0, NO_WORD},
        '{ROW_CHAR,  "/",    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_FULL, 9'd1}},
        '{ROW_CHAR,  9'h000, 1'b1, 1'b0, NO_WORD},
        '{ROW_LIMIT, 9'd511, 1'b0, 1'b0, NO_WORD}
    };

    // Limit per random group; a negative entry picks a random limit.
    localparam int LIMIT_PLAN [0:11] = '{511, 3, 0, 37, 256, 1, -1, 2, 255, -1, 64, 511};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [CHAR_W-1:0]   char_code;
    logic                cfg_wr_en;
    logic [COUNT_W-1:0]  cfg_wr_data;
    logic                empty;
    logic                pop;
    logic [7:0]          data_byte;
    logic                byte_valid;
    logic                finished;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  decoded_length;

    // Predictor state
    logic [ACC_W-1:0]    acc_q;
    logic [PEND_W-1:0]   pend_q;
    logic [COUNT_W-1:0]  count_q;
    logic                skip_q;
    logic [COUNT_W-1:0]  limit_q;

    dec_word_t decoded_words [$];
    int        mismatch_cnt = 0;
    int        send_idle_pct = 15;
    int        rcv_idle_pct = 61;
    bit        hold_req = 1'b0;
    bit        hold_taken = 1'b0;
    int        stall_cnt = 0;

    base64_stream_decoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .char_code      (char_code),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .empty          (empty),
        .pop            (pop),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .finished       (finished),
        .status         (status),
        .decoded_length (decoded_length)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic b64d_token_t classify_char(input logic [7:0] c);
        b64d_token_t t;
        t.kind  = TOK_INVALID;
        t.value = '0;
        if (c == 8'h00)
            t.kind = TOK_END;
        else if (c == "=")
            t.kind = TOK_PAD;
        else if (c >= "A" && c <= "Z")
        begin
            t.kind  = TOK_SYM;
            t.value = 6'(c - "A");
        end
        else if (c >= "a" && c <= "z")
        begin
            t.kind  = TOK_SYM;
            t.value = 6'(c - "a" + 8'd26);
        end
        else if (c >= "0" && c <= "9")
        begin
            t.kind  = TOK_SYM;
            t.value = 6'(c - "0" + 8'd52);
        end
        else if (c == "+")
        begin
            t.kind  = TOK_SYM;
            t.value = 6'd62;
        end
        else if (c == "/")
        begin
            t.kind  = TOK_SYM;
            t.value = 6'd63;
        end
        return t;
    endfunction

    function automatic logic [7:0] b64_char(input int idx);
        if (idx < 26)
            return 8'("A" + idx);
        if (idx < 52)
            return 8'("a" + idx - 26);
        if (idx < 62)
            return 8'("0" + idx - 52);
        return (idx == 62) ? 8'("+") : 8'("/");
    endfunction

    function automatic void clear_string();
        acc_q   = '0;
        pend_q  = '0;
        count_q = '0;
        skip_q  = 1'b0;
    endfunction

    // Advance the decode state by one character; has is set when a word is due.
    function automatic void decode_char(input logic [7:0] c, output bit has,
                                        output dec_word_t w);
        b64d_token_t        tok;
        logic [3:0]         total;
        logic [COUNT_W-1:0] lim;
        logic [2:0]         sh;
        has = 1'b0;
        w   = NO_WORD;
        tok = classify_char(c);
        if (skip_q)
        begin
            if (tok.kind == TOK_END)
                clear_string();
            return;
        end
        case (tok.kind)
            TOK_END:
            begin
                has   = 1'b1;
                w.fin = 1'b1;
                w.st  = STATUS_OK;
                w.len = count_q;
                clear_string();
            end
            TOK_PAD, TOK_INVALID:
            begin
                has    = 1'b1;
                skip_q = 1'b1;
                w.fin  = 1'b1;
                w.st   = (tok.kind == TOK_PAD) ? STATUS_OK : STATUS_INVALID;
                w.len  = count_q;
            end
            default:
            begin
                acc_q = {acc_q[ACC_W-SYM_W-1:0], tok.value};
                total = {1'b0, pend_q} + 4'd6;
                if (total < 4'd8)
                begin
                    pend_q = total[2:0];
                    return;
                end
                lim = (MaxLength < LIMIT_W'(limit_q)) ? COUNT_W'(MaxLength) : limit_q;
                has = 1'b1;
                if (count_q >= lim)
                begin
                    skip_q = 1'b1;
                    w.fin  = 1'b1;
                    w.st   = STATUS_FULL;
                    w.len  = count_q;
                end
                else
                begin
                    sh      = 3'(total - 4'd8);
                    pend_q  = sh;
                    count_q = count_q + 1'b1;
                    w.data  = 8'(acc_q >> sh);
                    w.valid = 1'b1;
                    w.len   = count_q;
                end
            end
        endcase
    endfunction

    // Offer one character until taken, then book its expected word.
    task automatic send_char(input logic [7:0] c, input bit lit_on, input bit lit_has,
                             input dec_word_t lit);
        bit        has;
        dec_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_char(c, has, w);
        if (lit_on)
        begin
            if (lit_has)
                decoded_words.push_back(lit);
        end
        else if (has)
        begin
            decoded_words.push_back(w);
        end
    endtask

    // Write the byte limit once the block has gone quiet.
    task automatic write_limit(input logic [COUNT_W-1:0] v);
        push <= 1'b0;
        while (decoded_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_q = v;
    endtask

    initial
    begin
        logic [7:0] str [$];
        int         sent;
        int         n;
        int         r;
        int         lv;
        rst_n       = 1'b0;
        push        = 1'b0;
        char_code   = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        limit_q     = MAX_OUT_RESET;
        clear_string();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_LIMIT)
                write_limit(DIR_ROWS[i].val);
            else
                send_char(DIR_ROWS[i].val[7:0], DIR_ROWS[i].lit_on, DIR_ROWS[i].lit_has,
                          DIR_ROWS[i].lit);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 61 : 0;
            rcv_idle_pct  = (phase == 0) ? 61 : (phase == 1) ? 15 : 0;
            for (int grp = 0; grp < 4; grp++)
            begin
                lv = LIMIT_PLAN[phase*4 + grp];
                write_limit((lv < 0) ? COUNT_W'($urandom_range(511)) : COUNT_W'(lv));
                if (phase == 2 && grp == 0)
                    hold_req = 1'b1;
                sent = 0;
                while (sent < GROUP_ITEMS)
                begin
                    str.delete();
                    r = $urandom_range(99);
                    if (grp == 0 && sent == 0)
                    begin
                        // long string: runs into the byte cap
                        repeat (LONG_CHARS) str.push_back(b64_char($urandom_range(63)));
                    end
                    else if (r < 70)
                    begin
                        n = $urandom_range(20);
                        repeat (n) str.push_back(b64_char($urandom_range(63)));
                        if ($urandom_range(2) == 0)
                        begin
                            repeat ($urandom_range(1, 2)) str.push_back("=");
                            if ($urandom_range(3) == 0)
                                repeat ($urandom_range(3))
                                    str.push_back(8'($urandom_range(1, 255)));
                        end
                    end
                    else if (r < 85)
                    begin
                        // valid prefix followed by one to four stray bytes
                        repeat ($urandom_range(10)) str.push_back(b64_char($urandom_range(63)));
                        repeat ($urandom_range(1, 4)) str.push_back(8'($urandom_range(1, 255)));
                    end
                    else
                    begin
                        repeat ($urandom_range(8)) str.push_back(8'($urandom_range(1, 255)));
                    end
                    str.push_back(8'h00);
                    foreach (str[k])
                        send_char(str[k], 1'b0, 1'b0, NO_WORD);
                    sent += str.size();
                end
            end
        end

        push <= 1'b0;
        while (decoded_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                // hold off popping so the block backs up and stalls push
                hold_taken = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        dec_word_t got;
        dec_word_t want;
        if (rst_n && pop && !empty)
        begin
            got = '{data_byte, byte_valid, finished, status, decoded_length};
            if (decoded_words.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected word: data=%h valid=%b fin=%b st=%0d len=%0d",
                             got.data, got.valid, got.fin, got.st, got.len);
            end
            else
            begin
                want = decoded_words.pop_front();
                if (got.data !== want.data || got.valid !== want.valid ||
                    got.fin !== want.fin || got.st !== want.st || got.len !== want.len)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"word mismatch: exp data=%h valid=%b fin=%b st=%0d len=%0d",
                                  " / got data=%h valid=%b fin=%b st=%0d len=%0d"},
                                 want.data, want.valid, want.fin, want.st, want.len,
                                 got.data, got.valid, got.fin, got.st, got.len);
                end
            end
        end
    end

    // Watchdog: too many cycles without any word moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stall_cnt = 0;
        end
        else
        begin
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
